// File: hw/rtl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and bit functions for the SM3 compression core.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned WinLen  = 16;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [7:0]      vstate_t;
  typedef logic [3:0]       wcnt_t;
  typedef logic [5:0]       rnd_t;
  typedef logic [2:0]       didx_t;

  localparam wcnt_t LastWord = 4'd15;
  localparam rnd_t  LastRnd  = 6'(NumRnd - 1);
  localparam rnd_t  SwapRnd  = 6'd15;
  localparam didx_t LastIdx  = 3'd7;

  localparam word_t TLow  = 32'h79cc4519;
  localparam word_t THigh = 32'h7a879d8a;
  // high constant pre-rotated by sixteen, the first round that uses it
  localparam word_t THigh16 = {THigh[15:0], THigh[31:16]};

  localparam vstate_t Iv = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  typedef struct packed {
    logic shift;
    logic load;
  } sched_ctrl_t;

  // n is a constant between 1 and 31 at every call
  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  function automatic word_t p0(word_t x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic word_t p1(word_t x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sm3_msg_sched.sv
// ----------------------------------------------------------------------------
// sm3_msg_sched
// Sixteen-word sliding window: shifts in message words while loading, then
// shifts in expanded words, one per round, giving W[j] and W[j+4].
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_msg_sched (
  input  wire                  clk_i,
  input  sm3_pkg::sched_ctrl_t ctrl_i,
  input  sm3_pkg::word_t       word_i,
  output sm3_pkg::word_t       w_j_o,
  output sm3_pkg::word_t       w_j4_o
);
  import sm3_pkg::*;

  word_t win_q [WinLen];
  word_t exp_word;

  assign exp_word = p1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 15))
                  ^ rotl(win_q[3], 7) ^ win_q[10];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinLen-1] <= ctrl_i.load ? word_i : exp_word;
    end
  end

  assign w_j_o  = win_q[0];
  assign w_j4_o = win_q[4];

endmodule

`default_nettype wire

// File: hw/rtl/sm3_round.sv
// ----------------------------------------------------------------------------
// sm3_round
// One SM3 compression round; the sequencer applies it 64 times per block.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_round (
  input  sm3_pkg::vstate_t v_i,
  input  sm3_pkg::word_t   w_j_i,
  input  sm3_pkg::word_t   w_j4_i,
  input  sm3_pkg::word_t   tj_i,
  input  wire              high_i,
  output sm3_pkg::vstate_t v_o
);
  import sm3_pkg::*;

  word_t a12, ss1, ss2, ff, gg, tt1, tt2;

  always_comb begin
    a12 = rotl(v_i[0], 12);
    ss1 = rotl(a12 + v_i[4] + tj_i, 7);
    ss2 = ss1 ^ a12;
    if (high_i) begin
      ff = (v_i[0] & v_i[1]) | (v_i[0] & v_i[2]) | (v_i[1] & v_i[2]);
      gg = (v_i[4] & v_i[5]) | (~v_i[4] & v_i[6]);
    end else begin
      ff = v_i[0] ^ v_i[1] ^ v_i[2];
      gg = v_i[4] ^ v_i[5] ^ v_i[6];
    end
    tt1 = ff + v_i[3] + ss2 + (w_j_i ^ w_j4_i);
    tt2 = gg + v_i[7] + ss1 + w_j_i;
    v_o[0] = tt1;
    v_o[1] = v_i[0];
    v_o[2] = rotl(v_i[1], 9);
    v_o[3] = v_i[2];
    v_o[4] = p0(tt2);
    v_o[5] = v_i[4];
    v_o[6] = rotl(v_i[5], 19);
    v_o[7] = v_i[6];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sm3_hash_compression_top.sv
// ----------------------------------------------------------------------------
// sm3_hash_compression_top
// SM3 compression core: takes padded message words, compresses each 512-bit
// block and emits the eight digest words after the final block.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  message_word, first/final_block
//   out      source     out_valid_o / out_stall_i digest_word, digest_index, last_word
//
// words 1..15 of a block are only taken into the window; the sixteenth starts
// the 64 rounds of the shared round unit.
// after a final block eight digest words follow, one per unstalled cycle.
// in_stall_o is high during rounds and while the digest is emitted.
// reset loads the standard initial value and clears the word count.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_compression_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  sm3_pkg::word_t      message_word_i,
  input  wire                 first_block_i,
  input  wire                 final_block_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output sm3_pkg::word_t      digest_word_o,
  output sm3_pkg::didx_t      digest_index_o,
  output logic                last_word_o
);
  import sm3_pkg::*;

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StEmit
  } state_e;

  state_e      state_q, state_d;
  wcnt_t       wcnt_q, wcnt_d;
  rnd_t        rnd_q, rnd_d;
  didx_t       idx_q, idx_d;
  logic        final_q, final_d;
  word_t       tj_q, tj_d;
  vstate_t     v_q, v_d, cv_q, cv_d, v_next;
  word_t       w_j, w_j4;
  sched_ctrl_t sched_ctrl;
  logic        in_acc, out_acc;

  assign in_stall_o  = (state_q != StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign sched_ctrl.load  = (state_q == StLoad);
  assign sched_ctrl.shift = in_acc || (state_q == StRound);

  sm3_msg_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_i (message_word_i),
    .w_j_o  (w_j),
    .w_j4_o (w_j4)
  );

  sm3_round u_round (
    .v_i    (v_q),
    .w_j_i  (w_j),
    .w_j4_i (w_j4),
    .tj_i   (tj_q),
    .high_i (rnd_q[5:4] != 2'b00),
    .v_o    (v_next)
  );

  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    final_d = final_q;
    tj_d    = tj_q;
    v_d     = v_q;
    cv_d    = cv_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          wcnt_d = wcnt_q + 4'd1;
          if (wcnt_q == LastWord) begin
            state_d = StRound;
            rnd_d   = '0;
            tj_d    = TLow;
            final_d = final_block_i;
            if (first_block_i) begin
              cv_d = Iv;
              v_d  = Iv;
            end else begin
              v_d = cv_q;
            end
          end
        end
      end
      StRound: begin
        v_d   = v_next;
        rnd_d = rnd_q + 6'd1;
        tj_d  = (rnd_q == SwapRnd) ? THigh16 : rotl(tj_q, 1);
        if (rnd_q == LastRnd) begin
          cv_d    = cv_q ^ v_next;
          idx_d   = '0;
          state_d = final_q ? StEmit : StLoad;
        end
      end
      StEmit: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LastIdx) begin
            state_d = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      wcnt_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
      cv_q    <= Iv;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      final_q <= final_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tj_q <= tj_d;
    v_q  <= v_d;
  end

  assign digest_word_o  = cv_q[idx_q];
  assign digest_index_o = idx_q;
  assign last_word_o    = (idx_q == LastIdx);

`ifndef SYNTHESIS
  a_emit_stalls_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest is emitted");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound && rnd_q == LastRnd) |=> (state_q != StRound))
    else $error("round sequence overran");

  a_emit_at_block_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wcnt_q == 4'd0))
    else $error("digest emitted mid block");

  a_last_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> !out_valid_o)
    else $error("digest emit ran past last word");
`endif

endmodule

`default_nettype wire

// File: verif/sm3_hash_compression_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_compression_checker
// Watches both channels of the SM3 core. Accepted message words are
// collected into 512-bit blocks and folded into a private chaining value.
// After a final block the eight digest words are queued and compared, in
// order, with what the core hands out. Counts go back to the bench top.
// ----------------------------------------------------------------------------

module sm3_hash_compression_checker (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire            in_stall_i,
  input  sm3_pkg::word_t message_word_i,
  input  wire            first_block_i,
  input  wire            final_block_i,
  input  wire            out_valid_i,
  input  wire            out_stall_i,
  input  sm3_pkg::word_t digest_word_i,
  input  sm3_pkg::didx_t digest_index_i,
  input  wire            last_word_i,
  output int             err_count_o,
  output int             pending_o,
  output int             blocks_o,
  output int             digests_o
);
  import sm3_pkg::*;

  typedef word_t [15:0] blk_t;
  typedef word_t [7:0]  chain_t;

  typedef struct packed {
    word_t word;
    didx_t idx;
    logic  last;
  } digest_rec_t;

  localparam wcnt_t LastSlot = 4'd15;
  localparam word_t RoundConstEarly = 32'h79cc4519;
  localparam word_t RoundConstLate  = 32'h7a879d8a;
  localparam chain_t InitChain = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  chain_t        chain_value;
  blk_t          block_buf;
  wcnt_t         word_idx;
  digest_rec_t   digest_q[$];
  int            errors = 0;
  int            pending = 0;
  int            blocks = 0;
  int            digests = 0;

  assign err_count_o = errors;
  assign pending_o   = pending;
  assign blocks_o    = blocks;
  assign digests_o   = digests;

  function automatic word_t rot_left(word_t x, int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic chain_t fold_block(chain_t cv, blk_t blk);
    word_t w [0:67];
    word_t v [0:7];
    word_t x, a12, t, ss1, ss2, ff, gg, tt1, tt2;
    chain_t nxt;
    int j;
    for (j = 0; j < 16; j++) w[j] = blk[j];
    for (j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15);
      w[j] = x ^ rot_left(x, 15) ^ rot_left(x, 23) ^ rot_left(w[j-13], 7) ^ w[j-6];
    end
    for (j = 0; j < 8; j++) v[j] = cv[j];
    for (j = 0; j < 64; j++) begin
      a12 = rot_left(v[0], 12);
      t   = (j < 16) ? RoundConstEarly : RoundConstLate;
      ss1 = rot_left(word_t'(a12 + v[4] + rot_left(t, j)), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2];
      v[2] = rot_left(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rot_left(v[5], 19);
      v[5] = v[4];
      v[4] = tt2 ^ rot_left(tt2, 9) ^ rot_left(tt2, 17);
    end
    for (j = 0; j < 8; j++) nxt[j] = cv[j] ^ v[j];
    return nxt;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_rec_t want;
    int k;
    if (!rst_ni) begin
      chain_value = InitChain;
      word_idx = '0;
      digest_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", digest_word_i, '0);
        end else begin
          want = digest_q.pop_front();
          if (digest_word_i !== want.word)
            report_mismatch("digest_word", digest_word_i, want.word);
          if (digest_index_i !== want.idx)
            report_mismatch("digest_index", word_t'(digest_index_i), word_t'(want.idx));
          if (last_word_i !== want.last)
            report_mismatch("last_word", word_t'(last_word_i), word_t'(want.last));
          digests++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        block_buf[word_idx] = message_word_i;
        if (word_idx == LastSlot) begin
          if (first_block_i) chain_value = InitChain;
          chain_value = fold_block(chain_value, block_buf);
          blocks++;
          if (final_block_i) begin
            for (k = 0; k < 8; k++)
              digest_q.push_back('{chain_value[k], didx_t'(k), k == 7});
          end
        end
        word_idx = word_idx + 1'b1;
      end
      pending = digest_q.size();
    end
  end

endmodule

// File: verif/sm3_hash_compression_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_compression_top_tb
// Feeds padded messages to the SM3 core: the standard three-byte vector,
// then random messages of one to four blocks, chained ones without a first
// flag, ones with junk flags on inner words and unfinished ones. Sender and
// receiver idle at random; the checker predicts and compares the digests.
// ----------------------------------------------------------------------------

module sm3_hash_compression_top_tb;
  import sm3_pkg::*;

  typedef enum int {MsgPlain, MsgChained, MsgNoisy, MsgOpen} msg_kind_e;
  typedef enum int {RxFree, RxLight, RxHeavy, RxToggle} rx_mode_e;

  localparam int WordTarget = 410;
  localparam int HoldCycles = 800;
  localparam int TailCycles = 120;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t msg_word = '0;
  logic  first_blk = 1'b0;
  logic  final_blk = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t dig_word;
  didx_t dig_idx;
  logic  dig_last;

  int err_count, pending, blocks, digests;
  int words_sent = 0;
  int burst_left = 0;
  int msg_count = 0;
  int holds = 0;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sm3_hash_compression_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .message_word_i (msg_word),
    .first_block_i  (first_blk),
    .final_block_i  (final_blk),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .digest_word_o  (dig_word),
    .digest_index_o (dig_idx),
    .last_word_o    (dig_last)
  );

  sm3_hash_compression_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .message_word_i (msg_word),
    .first_block_i  (first_blk),
    .final_block_i  (final_blk),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .digest_word_i  (dig_word),
    .digest_index_i (dig_idx),
    .last_word_i    (dig_last),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .blocks_o       (blocks),
    .digests_o      (digests)
  );

  // offer one word, returns on the falling edge after it was taken
  task automatic send_word(input word_t w, input logic fb, input logic lb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    msg_word  <= w;
    first_blk <= fb;
    final_blk <= lb;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input msg_kind_e kind);
    int nblk, b, i;
    logic fb, lb;
    word_t w;
    if (kind == MsgPlain && $urandom_range(0, 7) == 0) nblk = 4;
    else nblk = $urandom_range(1, 3);
    for (b = 0; b < nblk; b++) begin
      fb = (b == 0) && (kind != MsgChained);
      lb = (b == nblk - 1) && (kind != MsgOpen);
      for (i = 0; i < 16; i++) begin
        case ($urandom_range(0, 9))
          0: w = '0;
          1: w = '1;
          2: w = word_t'(1) << $urandom_range(0, 31);
          default: w = $urandom;
        endcase
        if (i != 15 && kind == MsgNoisy)
          send_word(w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
          send_word(w, fb, lb);
      end
    end
  endtask

  // drop valid and wait until every queued digest word has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    rx_mode_e rx_mode;
    int mode_left;
    int hold_n;
    rx_mode = RxFree;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_n = 0; hold_n < HoldCycles; hold_n++) @(negedge clk);
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (rx_mode)
        RxFree:  out_stall <= 1'b0;
        RxLight: out_stall <= ($urandom_range(0, 4) == 0);
        RxHeavy: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin
    msg_kind_e kind;
    int i, r;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // standard "abc" vector, inner words carry flags that must be ignored
    for (i = 0; i < 16; i++) begin
      if (i == 15) send_word(32'h00000018, 1'b1, 1'b1);
      else send_word((i == 0) ? 32'h61626380 : 32'h0, 1'(i), 1'(i >> 1));
    end
    msg_count++;

    while (words_sent < WordTarget) begin
      r = $urandom_range(0, 19);
      if (msg_count < 5) kind = msg_kind_e'(msg_count - 1);
      else if (r < 10) kind = MsgPlain;
      else if (r < 13) kind = MsgChained;
      else if (r < 17) kind = MsgNoisy;
      else kind = MsgOpen;
      if (msg_count == 5 || msg_count == 15) begin
        hold_req = 1'b1;
        holds++;
        kind = MsgPlain;
      end
      send_message(kind);
      msg_count++;
      if (msg_count % 7 == 0) drain();
    end
    drain();
    repeat (TailCycles) @(negedge clk);

    $display("run: %0d words in %0d messages, %0d blocks folded, %0d digest words compared",
             words_sent, msg_count, blocks, digests);
    $display("run: chained, junk-flag and unfinished messages mixed in, %0d long receiver holds",
             holds);
    if (err_count == 0 && pending == 0) begin
      $display("sm3_hash_compression_top_tb: done, clean");
    end else begin
      $display("sm3_hash_compression_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d digest words outstanding", pending);
    $display("sm3_hash_compression_top_tb: done, errors");
    $finish;
  end

endmodule
